>>> sv/mtu_pkg.sv
// Shared types, codes and constant tables of the matrix transform unit.
// Depends on nothing; mtu_div and the top unit refer to it by scoped names.
`timescale 1ns / 1ps

package mtu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int ELEM_W        = 32;
	localparam int MAT_DEPTH     = 32;   // two banks of 16 elements
	localparam int OPND_DEPTH    = 16;
	localparam int S_TDATA_W     = 136;
	localparam int M_TDATA_W     = 128;

	typedef enum logic [2:0] {
		ACT_IDENTITY  = 3'd0,
		ACT_WRITE     = 3'd1,
		ACT_STAGE     = 3'd2,
		ACT_APPEND    = 3'd3,
		ACT_INVERT    = 3'd4,
		ACT_TRANSFORM = 3'd5,
		ACT_READ      = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SINGULAR = 2'd1,
		STAT_SAT      = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_MAC,
		ST_MAC_FIN,
		ST_COF,
		ST_COF_FIN,
		ST_DET,
		ST_DET_FIN,
		ST_DIV_RD,
		ST_DIV_LD,
		ST_DIV_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               hit;
	} sat_t;

	// Index n of the three indexes left after dropping excl.
	function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] excl);
		return (n < excl) ? n : n + 2'd1;
	endfunction

	// Row position used at column position pos by permutation term.
	function automatic logic [1:0] perm_sel(input logic [2:0] term, input logic [1:0] pos);
		logic [5:0] tbl;
		case (term)
			3'd0:    tbl = 6'b10_01_00;
			3'd1:    tbl = 6'b01_10_00;
			3'd2:    tbl = 6'b10_00_01;
			3'd3:    tbl = 6'b00_10_01;
			3'd4:    tbl = 6'b01_00_10;
			3'd5:    tbl = 6'b00_01_10;
			default: tbl = 6'b00_00_00;
		endcase
		case (pos)
			2'd0:    return tbl[1:0];
			2'd1:    return tbl[3:2];
			2'd2:    return tbl[5:4];
			default: return 2'd0;
		endcase
	endfunction

	// Odd permutations enter the 3x3 determinant negated.
	function automatic logic perm_neg(input logic [2:0] term);
		case (term) inside
			3'd1, 3'd2, 3'd5: return 1'b1;
			default:          return 1'b0;
		endcase
	endfunction

endpackage

>>> sv/mtu_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mtu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> sv/mtu_div.sv
// Radix-2 restoring divider, signed, truncating toward zero.
// Takes FRAC_BITS+32 steps; depends on mtu_pkg only for its default.
`timescale 1ns / 1ps

module mtu_div #(
	parameter int FRAC_BITS = mtu_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [FRAC_BITS+31:0]  num,
	input  logic signed [63:0]            den,
	output logic                          done,
	output logic signed [FRAC_BITS+32:0]  quot
);

	localparam int NW = FRAC_BITS + 32;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] nmag_q;
	logic [63:0]   dmag_q;
	logic [63:0]   rem_q;
	logic          neg_q;
	logic [64:0]   rem_sh;
	logic [64:0]   diff;
	logic          ge;

	assign rem_sh = {rem_q, nmag_q[NW-1]};
	assign diff   = rem_sh - {1'b0, dmag_q};
	assign ge     = ~diff[64];
	assign done   = busy_q && (cnt_q == '0);
	assign quot   = neg_q ? -$signed({1'b0, nmag_q}) : $signed({1'b0, nmag_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nmag_q <= num[NW-1] ? NW'(-num) : NW'(num);
			dmag_q <= den[63] ? 64'(-den) : 64'(den);
			rem_q  <= '0;
			neg_q  <= num[NW-1] ^ den[63];
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q  <= ge ? diff[63:0] : rem_sh[63:0];
			nmag_q <= {nmag_q[NW-2:0], ge};
		end
	end

endmodule

>>> sv/matrix4_transform_unit.sv
// Work per action: identity, write and stage finish straight from idle; read does one RAM read;
// transform computes three outputs of four products each; append sixteen entries; invert
// sixteen 3x3 cofactors, the determinant, then sixteen divides (skipped when singular).
// One item at a time through the shared multiplier, the matrix RAM port and
// the divider; the next item is taken while a result waits in the output reg.
// Reset: matrix reads as identity (per-entry valid bits clear), no result held.
`timescale 1ns / 1ps

module matrix4_transform_unit #(
	parameter int FRAC_BITS = mtu_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata: row[1:0], col[3:2], elem_value[35:4], point_x[67:36],
	//          point_y[99:68], point_z[131:100], zero pad
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mtu_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [2:0]                      s_tuser,   // action
	// m_tdata: read_value[31:0], out_x[63:32], out_y[95:64], out_z[127:96]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mtu_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [1:0]                      m_tuser    // status
);

	localparam int NUM_W = FRAC_BITS + 32;
	localparam int MAW   = $clog2(mtu_pkg::MAT_DEPTH);
	localparam int OAW   = $clog2(mtu_pkg::OPND_DEPTH);
	localparam logic signed [31:0] ONE_VAL = 32'sd1 <<< FRAC_BITS;

	function automatic mtu_pkg::sat_t sat32(input logic signed [63:0] v);
		mtu_pkg::sat_t r;
		if (v > 64'sd2147483647) begin
			r.val = 32'sh7fffffff;
			r.hit = 1'b1;
		end else if (v < -64'sd2147483648) begin
			r.val = 32'sh80000000;
			r.hit = 1'b1;
		end else begin
			r.val = v[31:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

	// input fields
	mtu_pkg::action_t   in_act;
	logic [1:0]         in_row;
	logic [1:0]         in_col;
	logic signed [31:0] in_elem;

	assign in_act  = mtu_pkg::action_t'(s_tuser);
	assign in_row  = s_tdata[1:0];
	assign in_col  = s_tdata[3:2];
	assign in_elem = s_tdata[35:4];

	// control state
	mtu_pkg::state_t  state_q, state_nxt;
	mtu_pkg::action_t op_q;
	logic [mtu_pkg::MAT_DEPTH-1:0] valid_q;
	logic       bank_q;
	logic [3:0] elem_q;
	logic [1:0] k_q;
	logic [2:0] ph_q;
	logic [2:0] term_q;
	logic       m_tvalid_q;
	logic       out_free;

	// datapath registers
	logic signed [31:0] px_q, py_q, pz_q;
	logic signed [31:0] opa_q, opb_q;
	logic signed [63:0] mul_q;
	logic signed [63:0] acc_q;
	logic               sat_q;
	mtu_pkg::status_t   status_q;
	logic signed [31:0] rv_q, ox_q, oy_q, oz_q;
	logic               rd_valid_s1, rd_diag_s1;
	mtu_pkg::status_t   out_status_q;
	logic signed [31:0] out_rv_q, out_x_q, out_y_q, out_z_q;

	// memory ports
	logic           m_we;
	logic [MAW-1:0] m_waddr, m_raddr;
	logic [31:0]    m_wdata, m_rdata;
	logic           o_we;
	logic [OAW-1:0] o_raddr;
	logic [31:0]    o_rdata;
	logic signed [31:0] mdata;

	// arithmetic
	logic               mul_en;
	logic signed [31:0] mul_a, mul_b, pt_sel;
	logic signed [63:0] pv;
	logic               is_append;
	logic [1:0]         cof_row, cof_col;
	logic               div_start, div_done;
	logic signed [NUM_W-1:0] div_num;
	logic signed [NUM_W:0]   div_quot;
	mtu_pkg::sat_t      sat_acc, sat_cof, sat_mul, sat_div;

	assign out_free  = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == mtu_pkg::ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tuser   = out_status_q;
	assign m_tdata   = {out_z_q, out_y_q, out_x_q, out_rv_q};
	assign is_append = (op_q == mtu_pkg::ACT_APPEND);

	// unwritten matrix entries read as identity
	assign mdata = rd_valid_s1 ? $signed(m_rdata) : (rd_diag_s1 ? ONE_VAL : 32'sd0);
	assign pv    = mul_q >>> FRAC_BITS;

	assign sat_acc = sat32(acc_q);
	assign sat_cof = sat32((elem_q[2] ^ elem_q[0]) ? -acc_q : acc_q);
	assign sat_mul = sat32(pv);
	assign sat_div = sat32(64'(div_quot));

	assign cof_row = mtu_pkg::skip_idx(mtu_pkg::perm_sel(term_q, ph_q[1:0]), elem_q[3:2]);
	assign cof_col = mtu_pkg::skip_idx(ph_q[1:0], elem_q[1:0]);
	assign div_num = {mdata, {FRAC_BITS{1'b0}}};

	always_comb begin
		case (k_q)
			2'd0:    pt_sel = px_q;
			2'd1:    pt_sel = py_q;
			2'd2:    pt_sel = pz_q;
			default: pt_sel = ONE_VAL;   // row 3 adds the translation as is
		endcase
	end

	mtu_ram #(
		.WIDTH (mtu_pkg::ELEM_W),
		.DEPTH (mtu_pkg::MAT_DEPTH)
	) u_mat_ram (
		.clk   (clk),
		.we    (m_we),
		.waddr (m_waddr),
		.wdata (m_wdata),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	mtu_ram #(
		.WIDTH (mtu_pkg::ELEM_W),
		.DEPTH (mtu_pkg::OPND_DEPTH)
	) u_opnd_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr ({in_row, in_col}),
		.wdata (in_elem),
		.raddr (o_raddr),
		.rdata (o_rdata)
	);

	mtu_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (acc_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mtu_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (in_act)
						mtu_pkg::ACT_APPEND,
						mtu_pkg::ACT_TRANSFORM: state_nxt = mtu_pkg::ST_MAC;
						mtu_pkg::ACT_INVERT:    state_nxt = mtu_pkg::ST_COF;
						mtu_pkg::ACT_READ:      state_nxt = mtu_pkg::ST_READ;
						default:                state_nxt = mtu_pkg::ST_DONE;
					endcase
				end
			end
			mtu_pkg::ST_READ: state_nxt = mtu_pkg::ST_DONE;
			mtu_pkg::ST_MAC: begin
				if (ph_q == 3'd2 && k_q == 2'd3) state_nxt = mtu_pkg::ST_MAC_FIN;
			end
			mtu_pkg::ST_MAC_FIN: begin
				if (is_append ? (elem_q == 4'd15) : (elem_q[1:0] == 2'd2)) begin
					state_nxt = mtu_pkg::ST_DONE;
				end else begin
					state_nxt = mtu_pkg::ST_MAC;
				end
			end
			mtu_pkg::ST_COF: begin
				if (ph_q == 3'd5 && term_q == 3'd5) state_nxt = mtu_pkg::ST_COF_FIN;
			end
			mtu_pkg::ST_COF_FIN: begin
				state_nxt = (elem_q == 4'd15) ? mtu_pkg::ST_DET : mtu_pkg::ST_COF;
			end
			mtu_pkg::ST_DET: begin
				if (ph_q == 3'd3 && k_q == 2'd3) state_nxt = mtu_pkg::ST_DET_FIN;
			end
			mtu_pkg::ST_DET_FIN: begin
				state_nxt = (acc_q == 64'sd0) ? mtu_pkg::ST_DONE : mtu_pkg::ST_DIV_RD;
			end
			mtu_pkg::ST_DIV_RD: state_nxt = mtu_pkg::ST_DIV_LD;
			mtu_pkg::ST_DIV_LD: state_nxt = mtu_pkg::ST_DIV_RUN;
			mtu_pkg::ST_DIV_RUN: begin
				if (div_done) begin
					state_nxt = (elem_q == 4'd15) ? mtu_pkg::ST_DONE : mtu_pkg::ST_DIV_RD;
				end
			end
			mtu_pkg::ST_DONE: begin
				if (out_free) state_nxt = mtu_pkg::ST_IDLE;
			end
			default: state_nxt = mtu_pkg::ST_IDLE;
		endcase
	end

	// memory addresses, write strobes and multiplier operands per state
	always_comb begin
		m_raddr   = {bank_q, in_row, in_col};
		o_raddr   = {k_q, elem_q[1:0]};
		m_we      = 1'b0;
		m_waddr   = {bank_q, in_row, in_col};
		m_wdata   = in_elem;
		o_we      = 1'b0;
		mul_en    = 1'b0;
		mul_a     = mdata;
		mul_b     = opa_q;
		div_start = 1'b0;
		unique case (state_q)
			mtu_pkg::ST_IDLE: begin
				m_we = s_tvalid && (in_act == mtu_pkg::ACT_WRITE);
				o_we = s_tvalid && (in_act == mtu_pkg::ACT_STAGE);
			end
			mtu_pkg::ST_MAC: begin
				m_raddr = is_append ? {bank_q, elem_q[3:2], k_q} : {bank_q, k_q, elem_q[1:0]};
				if (ph_q == 3'd1) begin
					mul_en = 1'b1;
					mul_b  = is_append ? $signed(o_rdata) : pt_sel;
				end
			end
			mtu_pkg::ST_MAC_FIN: begin
				// append builds the new matrix in the other bank
				m_we    = is_append;
				m_waddr = {~bank_q, elem_q};
				m_wdata = sat_acc.val;
			end
			mtu_pkg::ST_COF: begin
				m_raddr = {bank_q, cof_row, cof_col};
				if (ph_q == 3'd2) begin
					mul_en = 1'b1;
					mul_a  = opa_q;
					mul_b  = mdata;
				end else if (ph_q == 3'd4) begin
					mul_en = 1'b1;
					mul_a  = opa_q;
					mul_b  = opb_q;
				end
			end
			mtu_pkg::ST_COF_FIN: begin
				m_we    = 1'b1;
				m_waddr = {~bank_q, elem_q};
				m_wdata = sat_cof.val;
			end
			mtu_pkg::ST_DET: begin
				m_raddr = (ph_q == 3'd0) ? {bank_q, 2'd0, k_q} : {~bank_q, 2'd0, k_q};
				if (ph_q == 3'd2) begin
					mul_en = 1'b1;
					mul_a  = opa_q;
					mul_b  = mdata;
				end
			end
			mtu_pkg::ST_DIV_RD: begin
				// transposed cofactor gives the adjugate
				m_raddr = {~bank_q, elem_q[1:0], elem_q[3:2]};
			end
			mtu_pkg::ST_DIV_LD: div_start = 1'b1;
			mtu_pkg::ST_DIV_RUN: begin
				m_we    = div_done;
				m_waddr = {bank_q, elem_q};
				m_wdata = sat_div.val;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mtu_pkg::ST_IDLE;
			op_q       <= mtu_pkg::ACT_IDENTITY;
			valid_q    <= '0;
			bank_q     <= 1'b0;
			elem_q     <= '0;
			k_q        <= '0;
			ph_q       <= '0;
			term_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// raise valid as a result enters the output register, drop it on transfer
			if (state_q == mtu_pkg::ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (m_we) valid_q[m_waddr] <= 1'b1;
			case (state_q)
				mtu_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						op_q   <= in_act;
						elem_q <= '0;
						k_q    <= '0;
						ph_q   <= '0;
						term_q <= '0;
						// drop all entries back to identity
						if (in_act == mtu_pkg::ACT_IDENTITY) valid_q <= '0;
					end
				end
				mtu_pkg::ST_MAC: begin
					if (ph_q == 3'd2) begin
						ph_q <= '0;
						k_q  <= k_q + 2'd1;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				mtu_pkg::ST_MAC_FIN: begin
					elem_q <= elem_q + 4'd1;
					if (is_append && elem_q == 4'd15) bank_q <= ~bank_q;
				end
				mtu_pkg::ST_COF: begin
					if (ph_q == 3'd5) begin
						ph_q   <= '0;
						term_q <= (term_q == 3'd5) ? 3'd0 : term_q + 3'd1;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				mtu_pkg::ST_COF_FIN: elem_q <= elem_q + 4'd1;
				mtu_pkg::ST_DET: begin
					if (ph_q == 3'd3) begin
						ph_q <= '0;
						k_q  <= k_q + 2'd1;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				mtu_pkg::ST_DIV_RUN: begin
					if (div_done) elem_q <= elem_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_valid_s1 <= valid_q[m_raddr];
		rd_diag_s1  <= (m_raddr[3:2] == m_raddr[1:0]);
		if (mul_en) mul_q <= mul_a * mul_b;
		case (state_q)
			mtu_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					px_q     <= s_tdata[67:36];
					py_q     <= s_tdata[99:68];
					pz_q     <= s_tdata[131:100];
					status_q <= mtu_pkg::STAT_OK;
					sat_q    <= 1'b0;
					rv_q     <= '0;
					ox_q     <= '0;
					oy_q     <= '0;
					oz_q     <= '0;
					acc_q    <= '0;
				end
			end
			mtu_pkg::ST_READ: rv_q <= mdata;
			mtu_pkg::ST_MAC: begin
				if (ph_q == 3'd2) acc_q <= acc_q + pv;
			end
			mtu_pkg::ST_MAC_FIN: begin
				acc_q <= '0;
				sat_q <= sat_q | sat_acc.hit;
				if (!is_append) begin
					case (elem_q[1:0])
						2'd0:    ox_q <= sat_acc.val;
						2'd1:    oy_q <= sat_acc.val;
						default: oz_q <= sat_acc.val;
					endcase
				end
				status_q <= (sat_q | sat_acc.hit) ? mtu_pkg::STAT_SAT : mtu_pkg::STAT_OK;
			end
			mtu_pkg::ST_COF: begin
				case (ph_q)
					3'd1: opa_q <= mdata;
					3'd3: begin
						// inner product saturates before the third factor
						opb_q <= mdata;
						opa_q <= sat_mul.val;
						sat_q <= sat_q | sat_mul.hit;
					end
					3'd5: acc_q <= mtu_pkg::perm_neg(term_q) ? acc_q - pv : acc_q + pv;
					default: ;
				endcase
			end
			mtu_pkg::ST_COF_FIN: begin
				acc_q <= '0;
				sat_q <= sat_q | sat_cof.hit;
			end
			mtu_pkg::ST_DET: begin
				if (ph_q == 3'd1) opa_q <= mdata;
				if (ph_q == 3'd3) acc_q <= acc_q + pv;
			end
			mtu_pkg::ST_DET_FIN: begin
				// zero determinant: report and leave the matrix alone
				if (acc_q == 64'sd0) status_q <= mtu_pkg::STAT_SINGULAR;
			end
			mtu_pkg::ST_DIV_RUN: begin
				if (div_done) begin
					sat_q    <= sat_q | sat_div.hit;
					status_q <= (sat_q | sat_div.hit) ? mtu_pkg::STAT_SAT : mtu_pkg::STAT_OK;
				end
			end
			mtu_pkg::ST_DONE: begin
				if (out_free) begin
					out_status_q <= status_q;
					out_rv_q     <= rv_q;
					out_x_q      <= ox_q;
					out_y_q      <= oy_q;
					out_z_q      <= oz_q;
				end
			end
			default: ;
		endcase
	end

endmodule
